// ===== hw/rtl/upq_pkg.sv =====
// ----------------------------------------------------------------------------
// upq_pkg
// Shared sizes, command and status codes, and the controller command struct
// of the unsorted priority queue unit.
// ----------------------------------------------------------------------------
package upq_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int LEAVES     = 1 << IDX_W;

  localparam int VAL_W      = 32;
  localparam int PRIO_W     = 8;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int OUT_CNT_W  = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Remove-smallest is every code that is neither insert nor remove-largest.
  localparam logic [CMD_W-1:0] CMD_INSERT        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REM_MAX       = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REM_MAX_ALIAS = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic load;    // capture the accepted command
    logic search;  // register the winner of the compare tree
    logic commit;  // update the array and load the result register
  } dp_cmd_t;

endpackage

// ===== hw/rtl/upq_ctrl.sv =====
// ----------------------------------------------------------------------------
// upq_ctrl
// Command sequencer: accept, search, commit, and the result valid flag.
// ----------------------------------------------------------------------------
module upq_ctrl
  import upq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  // Commit only when the result register is free or drains this cycle.
  assign commit_ok  = (state_r == S_COMMIT) && (!out_valid_r || out_tready);

  assign dp_cmd.load   = in_tvalid && in_tready;
  assign dp_cmd.search = (state_r == S_SEARCH);
  assign dp_cmd.commit = commit_ok;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SEARCH;
      S_SEARCH: state_nxt = S_COMMIT;
      S_COMMIT: if (commit_ok) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (commit_ok) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/upq_datapath.sv =====
// ----------------------------------------------------------------------------
// upq_datapath
// Entry array, fill count, registered compare tree and result register.
// ----------------------------------------------------------------------------
module upq_datapath
  import upq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              dp_cmd,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [VAL_W-1:0]     in_value,
  input  logic [PRIO_W-1:0]    in_prio,
  output status_t              res_status,
  output logic [VAL_W-1:0]     res_value,
  output logic [PRIO_W-1:0]    res_prio,
  output logic [OUT_CNT_W-1:0] res_count
);

  logic [VAL_W-1:0]  val_r  [DEPTH];
  logic [PRIO_W-1:0] prio_r [DEPTH];
  logic [CNT_W-1:0]  count_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [VAL_W-1:0]  in_val_r;
  logic [PRIO_W-1:0] in_prio_r;

  logic [IDX_W-1:0]  win_idx_r;
  logic [VAL_W-1:0]  win_val_r;
  logic [PRIO_W-1:0] win_prio_r;

  status_t              status_r;
  logic [VAL_W-1:0]     rval_r;
  logic [PRIO_W-1:0]    rprio_r;
  logic [OUT_CNT_W-1:0] rcount_r;

  // Tree nodes in heap order: node 1 is the root, leaves start at LEAVES.
  logic              nd_vld  [2*LEAVES];
  logic [PRIO_W-1:0] nd_prio [2*LEAVES];
  logic [VAL_W-1:0]  nd_val  [2*LEAVES];
  logic [IDX_W-1:0]  nd_idx  [2*LEAVES];

  logic want_max;
  logic full;
  logic empty;
  logic is_insert;

  assign is_insert = (cmd_r == CMD_INSERT);
  assign want_max  = (cmd_r == CMD_REM_MAX) || (cmd_r == CMD_REM_MAX_ALIAS);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    logic take_hi;
    take_hi    = 1'b0;
    nd_vld[0]  = 1'b0;
    nd_prio[0] = '0;
    nd_val[0]  = '0;
    nd_idx[0]  = '0;
    for (int i = 0; i < LEAVES; i++) begin
      nd_vld[LEAVES+i]  = (i < DEPTH) && (i < int'(count_r));
      nd_prio[LEAVES+i] = prio_r[(i < DEPTH) ? i : 0];
      nd_val[LEAVES+i]  = val_r[(i < DEPTH) ? i : 0];
      nd_idx[LEAVES+i]  = IDX_W'(i);
    end
    // Left child is the older entry; it wins ties.
    for (int n = LEAVES - 1; n >= 1; n--) begin
      take_hi = nd_vld[2*n+1] &&
                (!nd_vld[2*n] ||
                 (want_max ? (nd_prio[2*n+1] > nd_prio[2*n])
                           : (nd_prio[2*n+1] < nd_prio[2*n])));
      nd_vld[n]  = nd_vld[2*n] || nd_vld[2*n+1];
      nd_prio[n] = take_hi ? nd_prio[2*n+1] : nd_prio[2*n];
      nd_val[n]  = take_hi ? nd_val[2*n+1]  : nd_val[2*n];
      nd_idx[n]  = take_hi ? nd_idx[2*n+1]  : nd_idx[2*n];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r     <= in_cmd;
      in_val_r  <= in_value;
      in_prio_r <= in_prio;
    end
    if (dp_cmd.search) begin
      win_idx_r  <= nd_idx[1];
      win_val_r  <= nd_val[1];
      win_prio_r <= nd_prio[1];
    end
    if (dp_cmd.commit) begin
      if (is_insert) begin
        if (!full) begin
          val_r[count_r[IDX_W-1:0]]  <= in_val_r;
          prio_r[count_r[IDX_W-1:0]] <= in_prio_r;
        end
      end else if (!empty) begin
        // Close the gap: younger entries move down one slot.
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (i >= int'(win_idx_r)) begin
            val_r[i]  <= val_r[i+1];
            prio_r[i] <= prio_r[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      rval_r  <= '0;
      rprio_r <= '0;
      if (is_insert) begin
        status_r <= full ? ST_OVERFLOW : ST_INSERTED;
        rcount_r <= full ? OUT_CNT_W'(count_r) : OUT_CNT_W'(count_r + 1'b1);
      end else if (empty) begin
        status_r <= ST_EMPTY;
        rcount_r <= '0;
      end else begin
        status_r <= ST_REMOVED;
        rval_r   <= win_val_r;
        rprio_r  <= win_prio_r;
        rcount_r <= OUT_CNT_W'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.commit) begin
      if (is_insert) begin
        if (!full) count_r <= count_r + 1'b1;
      end else if (!empty) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign res_status = status_r;
  assign res_value  = rval_r;
  assign res_prio   = rprio_r;
  assign res_count  = rcount_r;

endmodule

// ===== hw/rtl/unsorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// unsorted_priority_queue_unit
// Fixed-depth priority queue held as an unsorted array in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one command per transaction: tuser is the command
//   (insert, remove smallest priority, remove largest priority), tdata holds
//   the value and priority to insert. The out_ channel returns exactly one
//   result per command: tuser is the status, tdata the removed value and
//   priority (zero when nothing is removed) and the entry count afterwards.
//   Among equal priorities the oldest entry is removed; younger entries keep
//   their order.
//   Steps: a command is captured, the registered compare tree searches all
//   slots, then the array shifts and the result register loads. A new
//   command is taken only after the last one has committed; its result is
//   valid from that commit on.
//   Reset empties the queue; no clearing pass is needed.
//   When the receiver stalls, the result holds in its register and the block
//   still takes one more command; it then waits before commit until the held
//   result is taken.
// ----------------------------------------------------------------------------
module unsorted_priority_queue_unit
  import upq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value, [39:32] prio
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] removed_value,
                                            // [39:32] removed_prio,
                                            // [44:40] count, [47:45] zero
  output logic [STAT_W-1:0]     out_tuser   // [1:0] status
);

  dp_cmd_t              dp_cmd;
  status_t              res_status;
  logic [VAL_W-1:0]     res_value;
  logic [PRIO_W-1:0]    res_prio;
  logic [OUT_CNT_W-1:0] res_count;

  upq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd)
  );

  upq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .in_cmd     (in_tuser),
    .in_value   (in_tdata[VAL_W-1:0]),
    .in_prio    (in_tdata[VAL_W+PRIO_W-1:VAL_W]),
    .res_status (res_status),
    .res_value  (res_value),
    .res_prio   (res_prio),
    .res_count  (res_count)
  );

  assign out_tuser = res_status;
  assign out_tdata = {{(OUT_DATA_W - VAL_W - PRIO_W - OUT_CNT_W){1'b0}},
                      res_count, res_prio, res_value};

endmodule

// ===== test/tb_unsorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_unsorted_priority_queue_unit
// Self-checking bench for the unsorted priority queue unit. Commands go in
// through a queued stream driver. A scoreboard model of the slot array predicts
// each result when its command transaction is taken. The monitor checks every
// result transaction field by field. Directed cases come first, then random
// bursts with changing insert/remove mix and priority spread, under several
// idling and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_unsorted_priority_queue_unit;
  import upq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_REM_MIN = 2'd1;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 230;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
  } pq_cmd_t;

  typedef struct {
    status_t              status;
    logic [VAL_W-1:0]     value;
    logic [PRIO_W-1:0]    prio;
    logic [OUT_CNT_W-1:0] count;
  } pq_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [31:0] value, [39:32] prio
  logic [CMD_W-1:0]      in_tuser = '0;   // [1:0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [31:0] removed_value, [39:32] removed_prio,
                                          // [44:40] count, [47:45] zero
  logic [STAT_W-1:0]     out_tuser;       // [1:0] status

  unsorted_priority_queue_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  pq_cmd_t    pending_cmds[$];
  pq_result_t expected_results[$];

  // scoreboard copy of the queue contents
  logic [VAL_W-1:0]  slot_value[DEPTH];
  logic [PRIO_W-1:0] slot_prio[DEPTH];
  int                held = 0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  in_taken = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic pq_result_t queue_apply(pq_cmd_t c);
    pq_result_t r;
    bit         pick_max;
    int         sel;
    r = '{ST_EMPTY, '0, '0, '0};
    if (c.cmd == CMD_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        slot_value[held] = c.value;
        slot_prio[held]  = c.prio;
        held++;
        r.status = ST_INSERTED;
      end
    end else if (held != 0) begin
      pick_max = (c.cmd == CMD_REM_MAX) || (c.cmd == CMD_REM_MAX_ALIAS);
      sel = 0;
      // strict compare keeps the oldest among equal priorities
      for (int i = 1; i < held; i++) begin
        if (pick_max ? (slot_prio[i] > slot_prio[sel]) : (slot_prio[i] < slot_prio[sel]))
          sel = i;
      end
      r.value = slot_value[sel];
      r.prio  = slot_prio[sel];
      for (int i = sel; i + 1 < held; i++) begin
        slot_value[i] = slot_value[i + 1];
        slot_prio[i]  = slot_prio[i + 1];
      end
      held--;
      r.status = ST_REMOVED;
    end
    r.count = held[OUT_CNT_W-1:0];
    return r;
  endfunction

  task automatic push_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value,
                              logic [PRIO_W-1:0] prio);
    pending_cmds.push_back('{cmd, value, prio});
  endtask

  task automatic push_random_burst(int n);
    int                insert_pct;
    int                prio_mode;
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
    insert_pct = 0;
    prio_mode  = 0;
    for (int i = 0; i < n; i++) begin
      // change the mix now and then so the queue swings between empty and full
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
        prio_mode = $urandom_range(3);
      end
      if ($urandom_range(99) < insert_pct)
        cmd = CMD_INSERT;
      else
        case ($urandom_range(2))
          0: cmd = CMD_REM_MIN;
          1: cmd = CMD_REM_MAX;
          default: cmd = CMD_REM_MAX_ALIAS;
        endcase
      case ($urandom_range(7))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        default: value = $urandom;
      endcase
      case (prio_mode)
        0: prio = PRIO_W'($urandom_range(255));
        1: prio = PRIO_W'($urandom_range(3));
        2: prio = $urandom_range(1) ? 8'hff : 8'h00;
        default: prio = PRIO_W'(8'd120 + $urandom_range(15));
      endcase
      push_command(cmd, value, prio);
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [VAL_W-1:0] exp_v,
                                 logic [VAL_W-1:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
  endtask

  // command driver: hold an offered transaction until it is taken
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_cmds[0].cmd;
        in_tdata  <= {pending_cmds[0].prio, pending_cmds[0].value};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with its own long hold-off counter
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // input transaction: advance the queue and predict the result
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(queue_apply('{in_tuser, in_tdata[VAL_W-1:0],
                                               in_tdata[VAL_W+PRIO_W-1:VAL_W]}));
      pending_cmds.pop_front();
    end
  end

  // result monitor
  always @(posedge clk) begin
    pq_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got status %0d data %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tuser != exp_r.status)
          report_mismatch("status", VAL_W'(exp_r.status), VAL_W'(out_tuser));
        if (out_tdata[31:0] != exp_r.value)
          report_mismatch("removed_value", exp_r.value, out_tdata[31:0]);
        if (out_tdata[39:32] != exp_r.prio)
          report_mismatch("removed_prio", VAL_W'(exp_r.prio), VAL_W'(out_tdata[39:32]));
        if (out_tdata[44:40] != exp_r.count)
          report_mismatch("count", VAL_W'(exp_r.count), VAL_W'(out_tdata[44:40]));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d commands and %0d results outstanding", $time,
               pending_cmds.size(), expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [PRIO_W-1:0] tie_prios[12];
    tie_prios = '{8'd0, 8'd7, 8'd255, 8'd128, 8'd0, 8'd7, 8'd1, 8'd254,
                  8'd255, 8'd0, 8'd128, 8'd7};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // removes on an empty queue, including the alias code for remove-largest
    push_command(CMD_REM_MIN, 32'hdead_beef, 8'h5a);
    push_command(CMD_REM_MAX, 32'hffff_ffff, 8'hff);
    push_command(CMD_REM_MAX_ALIAS, 32'h0000_0001, 8'h01);
    // fill with extremes and repeated priorities
    push_command(CMD_INSERT, 32'h8000_0000, 8'd7);
    push_command(CMD_INSERT, 32'h7fff_ffff, 8'd255);
    push_command(CMD_INSERT, 32'h0000_0000, 8'd0);
    push_command(CMD_INSERT, 32'hffff_ffff, 8'd255);
    for (int i = 0; i < 12; i++)
      push_command(CMD_INSERT, $urandom, tie_prios[i]);
    // insert into a full queue
    push_command(CMD_INSERT, 32'hffff_ffff, 8'hff);
    push_command(CMD_REM_MIN, 32'h1234_5678, 8'h00);
    push_command(CMD_REM_MAX, 32'h0, 8'h00);
    push_command(CMD_REM_MAX_ALIAS, 32'h0, 8'h00);
    push_command(CMD_REM_MIN, 32'h0, 8'hff);
    push_command(CMD_REM_MAX, 32'h0, 8'h00);
    wait_drained();

    // no idling, with a long receiver hold-off at the start to fill the pipe
    hold_req++;
    push_random_burst(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 73;
    push_random_burst(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 73;
    push_random_burst(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 36;
    recv_stall_pct = 36;
    push_random_burst(PHASE_ITEMS);
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/upq_pkg.sv
hw/rtl/upq_ctrl.sv
hw/rtl/upq_datapath.sv
hw/rtl/unsorted_priority_queue_unit.sv
test/tb_unsorted_priority_queue_unit.sv
